// ===== hdl/ihp_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser package
// Shared types and constants for the IPv4 header parser: result kinds,
// header field numbers, status codes and the record passed from the front
// end to the back end.
// ----------------------------------------------------------------------------
package ihp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_OPTION  = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_STATUS  = 2'd3;

   // Header field numbers.
   localparam logic [3:0] FLD_VERSION  = 4'd0;
   localparam logic [3:0] FLD_IHL      = 4'd1;
   localparam logic [3:0] FLD_TOS      = 4'd2;
   localparam logic [3:0] FLD_TOTAL    = 4'd3;
   localparam logic [3:0] FLD_IDENT    = 4'd4;
   localparam logic [3:0] FLD_FLAGS    = 4'd5;
   localparam logic [3:0] FLD_FRAG_OFF = 4'd6;
   localparam logic [3:0] FLD_TTL      = 4'd7;
   localparam logic [3:0] FLD_PROTOCOL = 4'd8;
   localparam logic [3:0] FLD_CHECKSUM = 4'd9;
   localparam logic [3:0] FLD_SOURCE   = 4'd10;
   localparam logic [3:0] FLD_DEST     = 4'd11;

   // Byte positions at which a fixed header field completes.
   localparam logic [4:0] POS_TOS      = 5'd1;
   localparam logic [4:0] POS_TOTAL    = 5'd3;
   localparam logic [4:0] POS_IDENT    = 5'd5;
   localparam logic [4:0] POS_FLAGS    = 5'd6;
   localparam logic [4:0] POS_FRAG_OFF = 5'd7;
   localparam logic [4:0] POS_TTL      = 5'd8;
   localparam logic [4:0] POS_PROTOCOL = 5'd9;
   localparam logic [4:0] POS_CHECKSUM = 5'd11;
   localparam logic [4:0] POS_SOURCE   = 5'd15;
   localparam logic [4:0] POS_DEST     = 5'd19;

   // Length of the fixed header in bytes and the smallest legal IHL.
   localparam int unsigned FIXED_HDR_BYTES = 20;
   localparam logic [3:0]  MIN_IHL         = 4'd5;

   // Status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
   localparam logic [2:0] ST_BAD_IHL     = 3'd2;
   localparam logic [2:0] ST_BAD_TOTAL   = 3'd3;
   localparam logic [2:0] ST_SHORT_PKT   = 3'd4;

   // Queue between front and back end.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = 2;

   // Everything one byte produces: a field or data byte, the IHL field that
   // travels beside the version on the first byte, and the frame status.
   typedef struct packed {
      logic        main_valid;
      logic [1:0]  main_kind;
      logic [3:0]  main_id;
      logic [31:0] main_value;
      logic        ihl_valid;
      logic [3:0]  ihl_value;
      logic        status_valid;
      logic [2:0]  status_code;
   } rec_type;

endpackage

// ===== hdl/ihp_front.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser front end
// Accepts datagram bytes, tracks the position in the frame and builds one
// record of results for each byte that produces any.
// ----------------------------------------------------------------------------
module ihp_front #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  logic             q_full,
   output logic             q_push,
   output ihp_pkg::rec_type q_rec
);
   import ihp_pkg::*;

   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [3:0]            header_words_ff, header_words_in;
   logic [15:0]           total_bytes_ff, total_bytes_in;
   logic [23:0]           field_accum_ff, field_accum_in;
   logic                  header_bad_ff, header_bad_in;

   logic                  accept;
   logic [31:0]           accum;
   logic [5:0]            hlen;
   logic [COUNT_BITS-1:0] count_n;
   logic                  low_index;
   rec_type               rec;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign accum      = {field_accum_ff, req_tdata};
   assign low_index  = (byte_count_ff < COUNT_BITS'(FIXED_HDR_BYTES));

   // Classify the byte and compute the next parser state.
   always_comb begin
      rec             = '0;
      header_words_in = header_words_ff;
      header_bad_in   = header_bad_ff;
      total_bytes_in  = total_bytes_ff;

      if (byte_count_ff == '0) begin
         header_words_in = req_tdata[3:0];
         header_bad_in   = (req_tdata[3:0] < MIN_IHL);
         rec.main_valid  = 1'b1;
         rec.main_kind   = KIND_HEADER;
         rec.main_id     = FLD_VERSION;
         rec.main_value  = {28'd0, req_tdata[7:4]};
         rec.ihl_valid   = 1'b1;
         rec.ihl_value   = req_tdata[3:0];
      end else if (!header_bad_ff) begin
         if (low_index) begin
            rec.main_valid = 1'b1;
            rec.main_kind  = KIND_HEADER;
            case (byte_count_ff[4:0])
               POS_TOS: begin
                  rec.main_id    = FLD_TOS;
                  rec.main_value = {24'd0, req_tdata};
               end
               POS_TOTAL: begin
                  total_bytes_in = accum[15:0];
                  rec.main_id    = FLD_TOTAL;
                  rec.main_value = {16'd0, accum[15:0]};
               end
               POS_IDENT: begin
                  rec.main_id    = FLD_IDENT;
                  rec.main_value = {16'd0, accum[15:0]};
               end
               POS_FLAGS: begin
                  rec.main_id    = FLD_FLAGS;
                  rec.main_value = {29'd0, req_tdata[7:5]};
               end
               POS_FRAG_OFF: begin
                  rec.main_id    = FLD_FRAG_OFF;
                  rec.main_value = {19'd0, accum[12:0]};
               end
               POS_TTL: begin
                  rec.main_id    = FLD_TTL;
                  rec.main_value = {24'd0, req_tdata};
               end
               POS_PROTOCOL: begin
                  rec.main_id    = FLD_PROTOCOL;
                  rec.main_value = {24'd0, req_tdata};
               end
               POS_CHECKSUM: begin
                  rec.main_id    = FLD_CHECKSUM;
                  rec.main_value = {16'd0, accum[15:0]};
               end
               POS_SOURCE: begin
                  rec.main_id    = FLD_SOURCE;
                  rec.main_value = accum;
               end
               POS_DEST: begin
                  rec.main_id    = FLD_DEST;
                  rec.main_value = accum;
               end
               default: begin
                  rec.main_valid = 1'b0;
               end
            endcase
         end else if (byte_count_ff < COUNT_BITS'({header_words_ff, 2'b00})) begin
            rec.main_valid = 1'b1;
            rec.main_kind  = KIND_OPTION;
            rec.main_value = {24'd0, req_tdata};
         end else if (byte_count_ff < COUNT_BITS'(total_bytes_ff)) begin
            rec.main_valid = 1'b1;
            rec.main_kind  = KIND_PAYLOAD;
            rec.main_value = {24'd0, req_tdata};
         end
      end

      // Saturating byte counter.
      count_n = (byte_count_ff == '1) ? byte_count_ff : byte_count_ff + 1'b1;

      // Frame status, judged with the state as it stands after this byte.
      hlen = {header_words_in, 2'b00};
      if (req_tlast) begin
         rec.status_valid = 1'b1;
         if (count_n < COUNT_BITS'(hlen)) begin
            rec.status_code = ST_SHORT_HDR;
         end else if (header_words_in < MIN_IHL) begin
            rec.status_code = ST_BAD_IHL;
         end else if (total_bytes_in < {10'd0, hlen}) begin
            rec.status_code = ST_BAD_TOTAL;
         end else if (count_n < COUNT_BITS'(total_bytes_in)) begin
            rec.status_code = ST_SHORT_PKT;
         end else begin
            rec.status_code = ST_OK;
         end
      end

      byte_count_in  = count_n;
      field_accum_in = accum[23:0];
      if (req_tlast) begin
         byte_count_in   = '0;
         header_words_in = '0;
         total_bytes_in  = '0;
         field_accum_in  = '0;
         header_bad_in   = 1'b0;
      end
   end

   assign q_push = accept && (rec.main_valid || rec.ihl_valid || rec.status_valid);
   assign q_rec  = rec;

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         header_words_ff <= '0;
         total_bytes_ff  <= '0;
         field_accum_ff  <= '0;
         header_bad_ff   <= 1'b0;
      end else if (accept) begin
         byte_count_ff   <= byte_count_in;
         header_words_ff <= header_words_in;
         total_bytes_ff  <= total_bytes_in;
         field_accum_ff  <= field_accum_in;
         header_bad_ff   <= header_bad_in;
      end
   end

   // A frame end returns the counter to the start of a frame.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> byte_count_ff == '0)
      else $error("byte counter not cleared after frame end");

   // A bad header length flag always agrees with the stored IHL.
   a_bad_ihl: assert property (@(posedge clock) disable iff (reset)
      header_bad_ff |-> header_words_ff < MIN_IHL)
      else $error("bad header flag without a short IHL");

   // The queue is never written while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into a full queue");

endmodule

// ===== hdl/ihp_queue.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser record queue
// A short first-in first-out queue of result records that decouples the
// front end from the back end.
// ----------------------------------------------------------------------------
module ihp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ihp_pkg::rec_type push_rec,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output ihp_pkg::rec_type head_rec
);
   import ihp_pkg::*;

   rec_type              store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_rec = store_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // Occupancy never passes the depth, and a pop needs something to take.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

// ===== hdl/ihp_back.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser back end
// Walks through the results of the record at the head of the queue and
// hands them one at a time to the output register.
// ----------------------------------------------------------------------------
module ihp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  ihp_pkg::rec_type q_head,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,
   output logic [5:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import ihp_pkg::*;

   logic [2:0]  sent_ff, sent_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [3:0]  id_ff, id_in;
   logic [31:0] value_ff, value_in;
   logic        done_ff, done_in;

   logic        load;
   logic [2:0]  pend;
   logic [2:0]  sel;

   assign load = !valid_ff || rsp_tready;
   assign pend = {q_head.status_valid, q_head.ihl_valid, q_head.main_valid} & ~sent_ff;
   assign sel  = pend & (~pend + 3'd1);

   // Pick the next pending result of the head record in order.
   always_comb begin
      sent_in  = sent_ff;
      valid_in = valid_ff && !rsp_tready;
      kind_in  = kind_ff;
      id_in    = id_ff;
      value_in = value_ff;
      done_in  = done_ff;
      q_pop    = 1'b0;
      if (load && !q_empty) begin
         valid_in = 1'b1;
         done_in  = 1'b0;
         if (sel[0]) begin
            kind_in  = q_head.main_kind;
            id_in    = q_head.main_id;
            value_in = q_head.main_value;
         end else if (sel[1]) begin
            kind_in  = KIND_HEADER;
            id_in    = FLD_IHL;
            value_in = {28'd0, q_head.ihl_value};
         end else begin
            kind_in  = KIND_STATUS;
            id_in    = FLD_VERSION;
            value_in = {29'd0, q_head.status_code};
            done_in  = 1'b1;
         end
         if ((pend & ~sel) == 3'd0) begin
            q_pop   = 1'b1;
            sent_in = '0;
         end else begin
            sent_in = sent_ff | sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      id_ff    <= id_in;
      value_ff <= value_in;
      done_ff  <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = {id_ff, kind_ff};
   assign rsp_tlast  = done_ff;

   // Only a status result closes a frame.
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1:0] == KIND_STATUS)
      else $error("frame end on a result that is not a status");

endmodule

// ===== hdl/ipv4_header_parser_core.sv =====
// A byte's first result passes the record queue and the output register before it is valid.
// The front end takes one byte per cycle while the record queue is not full; each result
// holds the output register alone; the first byte gives two fields and a last byte adds a status.
// A four-entry record queue lets the front end keep accepting while the output is stalled.
// Reset is synchronous and active high; it clears the parser state, queue and output valid.
// ----------------------------------------------------------------------------
// IPv4 header parser
// Parses an IPv4 datagram byte by byte, emitting header fields, option and
// payload bytes, and a status result at the end of each frame.
// ----------------------------------------------------------------------------
module ipv4_header_parser_core #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // frame_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [5:0]  rsp_tuser,   // [1:0] kind, [5:2] field_id
   output logic        rsp_tlast    // frame_done
);
   import ihp_pkg::*;

   logic    q_full;
   logic    q_empty;
   logic    q_push;
   logic    q_pop;
   rec_type q_rec;
   rec_type q_head;

   // Front end: byte classification and parser state.
   ihp_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_rec      (q_rec)
   );

   // Record queue between the two ends.
   ihp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_rec (q_head)
   );

   // Back end: result sequencing and output register.
   ihp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== test/ihp_checker.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser checker
// Watches the byte requests and the result stream of the parser. It keeps
// its own copy of the parser state, works out the results that each
// accepted byte should give, and compares every result that leaves the
// block with the oldest one still owed.
// ----------------------------------------------------------------------------
module ihp_checker #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [31:0]        rsp_tdata,
   input  logic [5:0]         rsp_tuser,
   input  logic               rsp_tlast,
   output int unsigned        fail_count,
   output int unsigned        pending_count
);

   import ihp_pkg::*;

   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  id;
      logic [31:0] value;
      logic        done;
   } parse_result_type;

   // Results owed by the parser, oldest first.
   parse_result_type owed_results[$];

   // Parser state as the checker sees it.
   logic [COUNT_BITS-1:0] byte_pos;
   logic [3:0]            ihl_words;
   logic [15:0]           total_len;
   logic [31:0]           shift_word;
   logic                  ihl_bad;

   initial fail_count = 0;

   function automatic void owe_result(input logic [1:0] kind, input logic [3:0] id,
                                      input logic [31:0] value, input logic done);
      owed_results.push_back('{kind: kind, id: id, value: value, done: done});
   endfunction

   function automatic void clear_frame();
      byte_pos   = '0;
      ihl_words  = '0;
      total_len  = '0;
      shift_word = '0;
      ihl_bad    = 1'b0;
   endfunction

   // Works out what one accepted byte produces and updates the state.
   function automatic void parse_byte(input logic [7:0] b, input logic last);
      logic [COUNT_BITS-1:0] idx;
      int unsigned           hlen;
      logic [2:0]            status;
      idx        = byte_pos;
      shift_word = {shift_word[23:0], b};
      hlen       = ihl_words * 4;

      if (idx == 0) begin
         ihl_words = b[3:0];
         ihl_bad   = (b[3:0] < MIN_IHL);
         owe_result(KIND_HEADER, FLD_VERSION, {28'd0, b[7:4]}, 1'b0);
         owe_result(KIND_HEADER, FLD_IHL, {28'd0, b[3:0]}, 1'b0);
      end else if (!ihl_bad) begin
         case (idx)
            POS_TOS: begin
               owe_result(KIND_HEADER, FLD_TOS, {24'd0, b}, 1'b0);
            end
            POS_TOTAL: begin
               total_len = shift_word[15:0];
               owe_result(KIND_HEADER, FLD_TOTAL, {16'd0, total_len}, 1'b0);
            end
            POS_IDENT: begin
               owe_result(KIND_HEADER, FLD_IDENT, {16'd0, shift_word[15:0]}, 1'b0);
            end
            POS_FLAGS: begin
               owe_result(KIND_HEADER, FLD_FLAGS, {29'd0, b[7:5]}, 1'b0);
            end
            POS_FRAG_OFF: begin
               owe_result(KIND_HEADER, FLD_FRAG_OFF, {19'd0, shift_word[12:0]}, 1'b0);
            end
            POS_TTL: begin
               owe_result(KIND_HEADER, FLD_TTL, {24'd0, b}, 1'b0);
            end
            POS_PROTOCOL: begin
               owe_result(KIND_HEADER, FLD_PROTOCOL, {24'd0, b}, 1'b0);
            end
            POS_CHECKSUM: begin
               owe_result(KIND_HEADER, FLD_CHECKSUM, {16'd0, shift_word[15:0]}, 1'b0);
            end
            POS_SOURCE: begin
               owe_result(KIND_HEADER, FLD_SOURCE, shift_word, 1'b0);
            end
            POS_DEST: begin
               owe_result(KIND_HEADER, FLD_DEST, shift_word, 1'b0);
            end
            default: begin
               // Past the fixed part: options up to the header length, then
               // payload up to the total length, and padding is dropped.
               if (idx >= FIXED_HDR_BYTES) begin
                  if (idx < hlen)
                     owe_result(KIND_OPTION, FLD_VERSION, {24'd0, b}, 1'b0);
                  else if (idx < total_len)
                     owe_result(KIND_PAYLOAD, FLD_VERSION, {24'd0, b}, 1'b0);
               end
            end
         endcase
      end

      // The byte counter sticks at its maximum.
      if (byte_pos != '1)
         byte_pos = byte_pos + 1'b1;

      // The last byte of a frame closes it with a status.
      if (last) begin
         hlen = ihl_words * 4;
         if (byte_pos < hlen)
            status = ST_SHORT_HDR;
         else if (ihl_words < MIN_IHL)
            status = ST_BAD_IHL;
         else if (total_len < hlen)
            status = ST_BAD_TOTAL;
         else if (byte_pos < total_len)
            status = ST_SHORT_PKT;
         else
            status = ST_OK;
         owe_result(KIND_STATUS, FLD_VERSION, {29'd0, status}, 1'b1);
         clear_frame();
      end
   endfunction

   // Predict on every accepted request and compare every accepted result.
   always @(posedge clock) begin : monitor
      parse_result_type seen;
      parse_result_type want;
      if (reset) begin
         clear_frame();
         owed_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            parse_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            seen = '{kind: rsp_tuser[1:0], id: rsp_tuser[5:2], value: rsp_tdata,
                     done: rsp_tlast};
            if (owed_results.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result: kind %0d id %0d value %h done %b",
                           seen.kind, seen.id, seen.value, seen.done);
            end else begin
               want = owed_results.pop_front();
               if (seen !== want) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= MAX_REPORTS)
                     $display("result differs: expected kind %0d id %0d value %h done %b, %s",
                              want.kind, want.id, want.value, want.done,
                              $sformatf("got kind %0d id %0d value %h done %b",
                                        seen.kind, seen.id, seen.value, seen.done));
               end
            end
         end
      end
      pending_count = owed_results.size();
   end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser testbench
// Drives datagrams into the parser a byte at a time: a few hand-made frames,
// then random frames that are mostly well formed with some broken and some
// pure noise. Both sides idle at random, and once the receiver holds off
// long enough to fill the parser. The checker beside the block does the
// comparison.
// ----------------------------------------------------------------------------
module tb;

   import ihp_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 500000;
   localparam int unsigned RANDOM_BYTES    = 300;
   localparam int unsigned HOLD_OFF_CYCLES = 200;
   localparam int unsigned DRAIN_CYCLES    = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;

   // Sender controls and the frame being sent.
   logic        no_idle = 1'b0;
   logic        hold_off_req = 1'b0;
   logic [7:0]  frame_bytes[$];
   int unsigned frame_useful;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ipv4_header_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ihp_checker #(.COUNT_BITS(16)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offers one byte after a random gap and waits until it is accepted.
   // Valid is only lowered when a gap follows, so it never toggles twice in
   // one step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i])
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Builds a random frame. Most frames are well formed with random content;
   // the rest have a bad total length, an IHL below five, a cut-off end or
   // are plain noise. Dropped bytes count as useful only in a noise frame.
   task automatic build_frame();
      int unsigned mode;
      int unsigned ihl;
      int unsigned hlen;
      int unsigned total;
      int unsigned len;
      logic [7:0]  b;
      frame_bytes.delete();
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
         len = $urandom_range(1, 24);
         repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
         frame_useful = len;
      end else begin
         if (mode == 8)
            ihl = $urandom_range(0, 4);
         else if ($urandom_range(0, 7) == 0)
            ihl = 15;
         else
            ihl = $urandom_range(5, 7);
         hlen = ihl * 4;
         if (mode == 7)
            total = $urandom_range(0, hlen - 1);
         else
            total = hlen + $urandom_range(0, 10);
         if (mode == 8)
            len = $urandom_range(1, 20);
         else if (mode == 7)
            len = hlen + $urandom_range(0, 3);
         else if ($urandom_range(0, 4) == 0)
            len = $urandom_range(1, total - 1);
         else
            len = total + $urandom_range(0, 3);
         for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i == 0)
               b[3:0] = 4'(ihl);
            else if (i == 2)
               b = 8'(total >> 8);
            else if (i == 3)
               b = 8'(total);
            frame_bytes.push_back(b);
         end
         if (mode == 8)
            frame_useful = 1;
         else if (mode == 7)
            frame_useful = (len < hlen) ? len : hlen;
         else
            frame_useful = (len < total) ? len : total;
      end
   endtask

   // Receiver: a random stall before each result, with stretches of none,
   // and one long hold-off when the stimulus asks for it.
   initial begin : receiver
      int unsigned stall;
      int unsigned burst_left;
      logic        fast;
      burst_left = 0;
      fast = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (burst_left == 0) begin
            burst_left = 32;
            fast = ($urandom_range(0, 2) == 0);
         end
         burst_left--;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else begin
            stall = fast ? 0 : $urandom_range(0, 7);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned frames;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hand-made frames: a lone zero byte (bad IHL), a lone all-ones byte
      // (short header), a frame with IHL one that is long enough to report
      // the bad IHL, and a bare header, all ones after the total length.
      frame_bytes = '{8'h00};
      send_frame();
      frame_bytes = '{8'hFF};
      send_frame();
      frame_bytes = '{8'h41, 8'h12, 8'h34, 8'h56, 8'h78};
      send_frame();
      frame_bytes.delete();
      repeat (FIXED_HDR_BYTES) frame_bytes.push_back(8'hFF);
      frame_bytes[0] = 8'h45;
      frame_bytes[2] = 8'h00;
      frame_bytes[3] = 8'(FIXED_HDR_BYTES);
      send_frame();

      // Random frames; the third one comes with a long receiver hold-off
      // while the sender keeps the input busy.
      sent = 0;
      frames = 0;
      while (sent < RANDOM_BYTES) begin
         build_frame();
         no_idle = (frames == 2) || ($urandom_range(0, 3) == 0);
         if (frames == 2)
            hold_off_req = 1'b1;
         send_frame();
         sent += frame_useful;
         frames++;
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the pipeline time to show any stray result.
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ihp_pkg.sv
hdl/ihp_front.sv
hdl/ihp_queue.sv
hdl/ihp_back.sv
hdl/ipv4_header_parser_core.sv
test/ihp_checker.sv
test/tb.sv
